// ===== rtl/core/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Request and status codes shared by the sorted priority queue and its checker.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int KIND_W   = 2;
	localparam int STATUS_W = 2;

	// request kinds
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PEEK   = 2'd2;

	// result status
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

// ===== rtl/core/sorted_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Min-priority queue of (cost, vertex) entries held sorted in one memory.
//
// Entries sit in a circular buffer in ascending order (cost, then vertex;
// an equal entry goes ahead of the ones already stored). One request is taken
// at a time and gives one result transfer. A pop or peek on an empty queue,
// an insert on a full queue or an unknown kind goes straight to the result.
// An insert compares stored entries from the back of the queue forward (none
// on an empty queue, at most the stored count), using the single memory port
// pair and the one compare unit: each cycle reads one entry, compares it with
// the new one and, if it is not ahead, writes it one slot back. A pop only
// moves the head pointer. in_stall stays high from acceptance until the
// result has been loaded into the output register; a finished result waits
// there while the next request is already being worked on. The memory has no
// reset and needs no clearing pass; only data read from slots holding live
// entries is ever used.
// ----------------------------------------------------------------------------
module sorted_priority_queue #(
	parameter int DEPTH       = 16,
	parameter int COST_BITS   = 16,
	parameter int VERTEX_BITS = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// request channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [spq_pkg::KIND_W-1:0]    kind,
	input  logic [COST_BITS-1:0]          item_cost,
	input  logic [VERTEX_BITS-1:0]        item_vertex,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [spq_pkg::STATUS_W-1:0]  status,
	output logic [COST_BITS-1:0]          front_cost,
	output logic [VERTEX_BITS-1:0]        front_vertex,
	output logic [$clog2(DEPTH+1)-1:0]    entry_count,
	output logic                          is_empty
);

	import spq_pkg::*;

	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int ENT_W = COST_BITS + VERTEX_BITS;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,  // compare one entry, shift it back if not ahead
		S_PUT   = 5'b00100,  // write the new entry into the opened slot
		S_FRONT = 5'b01000,  // front entry arrives from memory
		S_OUT   = 5'b10000   // hand the result to the output register
	} state_t;

	// circular index helpers
	function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
		ptr_inc = (p == IDX_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [IDX_W-1:0] ptr_dec(input logic [IDX_W-1:0] p);
		ptr_dec = (p == '0) ? IDX_W'(DEPTH - 1) : p - 1'b1;
	endfunction

	// control state
	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [IDX_W-1:0]  head_q;   // physical slot of the front entry
	logic [IDX_W-1:0]  tail_q;   // physical slot after the last entry
	logic              out_valid_q;

	// working registers
	logic [IDX_W-1:0]       rd_ptr_q;   // slot whose data sits in rd_data_q
	logic [IDX_W-1:0]       wr_ptr_q;   // open slot during an insert
	logic [CNT_W-1:0]       rem_q;      // entries still to compare
	logic [COST_BITS-1:0]   new_cost_q;
	logic [VERTEX_BITS-1:0] new_vertex_q;
	logic                   pop_q;
	logic [STATUS_W-1:0]    res_status_q;
	logic [COST_BITS-1:0]   res_cost_q;
	logic [VERTEX_BITS-1:0] res_vertex_q;

	// output register payload
	logic [STATUS_W-1:0]    out_status_q;
	logic [COST_BITS-1:0]   out_cost_q;
	logic [VERTEX_BITS-1:0] out_vertex_q;
	logic [CNT_W-1:0]       out_count_q;
	logic                   out_empty_q;

	// entry memory
	logic [ENT_W-1:0] mem_q [DEPTH];
	logic [ENT_W-1:0] rd_data_q;
	logic [IDX_W-1:0] rd_addr;
	logic [IDX_W-1:0] wr_addr;
	logic [ENT_W-1:0] wr_data;
	logic             wr_en;

	logic accept;
	logic full;
	logic out_free;
	logic entry_first;  // stored entry orders strictly ahead of the new one
	logic shift;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign full     = (count_q == CNT_W'(DEPTH));
	assign out_free = !out_valid_q || !out_stall;
	assign shift    = (state_q == S_SCAN) && !entry_first;

	spq_cmp #(
		.COST_BITS   (COST_BITS),
		.VERTEX_BITS (VERTEX_BITS)
	) u_cmp (
		.a_cost   (rd_data_q[ENT_W-1:VERTEX_BITS]),
		.a_vertex (rd_data_q[VERTEX_BITS-1:0]),
		.b_cost   (new_cost_q),
		.b_vertex (new_vertex_q),
		.a_first  (entry_first)
	);

	// memory port selection
	always_comb begin
		rd_addr = rd_ptr_q;
		wr_en   = 1'b0;
		wr_addr = wr_ptr_q;
		wr_data = {new_cost_q, new_vertex_q};
		unique case (state_q)
			S_IDLE: begin
				// insert looks at the back entry, pop and peek at the front one
				rd_addr = (kind == KIND_INSERT) ? ptr_dec(tail_q) : head_q;
			end
			S_SCAN: begin
				rd_addr = ptr_dec(rd_ptr_q);
				wr_en   = shift;
				wr_data = rd_data_q;
			end
			S_PUT: begin
				wr_en = 1'b1;
			end
			S_FRONT, S_OUT: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	// sequencer and queue bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (kind) inside
							KIND_INSERT: begin
								if (full) begin
									state_q <= S_OUT;
								end else if (count_q == '0) begin
									state_q <= S_PUT;
								end else begin
									state_q <= S_SCAN;
								end
							end
							KIND_POP, KIND_PEEK: begin
								state_q <= (count_q == '0) ? S_OUT : S_FRONT;
							end
							default: begin
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_SCAN: begin
					// stop at the first entry ahead of the new one, or at the front
					if (!shift || rem_q == CNT_W'(1)) begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					count_q <= count_q + 1'b1;
					tail_q  <= ptr_inc(tail_q);
					state_q <= S_OUT;
				end
				S_FRONT: begin
					if (pop_q) begin
						count_q <= count_q - 1'b1;
						head_q  <= ptr_inc(head_q);
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					new_cost_q   <= item_cost;
					new_vertex_q <= item_vertex;
					wr_ptr_q     <= tail_q;
					rd_ptr_q     <= rd_addr;
					rem_q        <= count_q;
					pop_q        <= (kind == KIND_POP);
					res_cost_q   <= '0;
					res_vertex_q <= '0;
					case (kind) inside
						KIND_INSERT: begin
							res_status_q <= full ? ST_FULL : ST_DONE;
						end
						KIND_POP, KIND_PEEK: begin
							res_status_q <= (count_q == '0) ? ST_EMPTY : ST_DONE;
						end
						default: begin
							res_status_q <= ST_DONE;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (shift) begin
					wr_ptr_q <= rd_ptr_q;
					rd_ptr_q <= rd_addr;
					rem_q    <= rem_q - 1'b1;
				end
			end
			S_FRONT: begin
				res_cost_q   <= rd_data_q[ENT_W-1:VERTEX_BITS];
				res_vertex_q <= rd_data_q[VERTEX_BITS-1:0];
			end
			S_OUT: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_cost_q   <= res_cost_q;
					out_vertex_q <= res_vertex_q;
					out_count_q  <= count_q;
					out_empty_q  <= (count_q == '0);
				end
			end
			S_PUT: begin
			end
			default: begin
			end
		endcase
	end

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign front_cost   = out_cost_q;
	assign front_vertex = out_vertex_q;
	assign entry_count  = out_count_q;
	assign is_empty     = out_empty_q;

endmodule

// ===== rtl/core/spq_cmp.sv =====
// ----------------------------------------------------------------------------
// spq_cmp
// Ordering unit: is entry A strictly ahead of entry B (cost, then vertex).
// ----------------------------------------------------------------------------
module spq_cmp #(
	parameter int COST_BITS   = 16,
	parameter int VERTEX_BITS = 8
) (
	input  logic [COST_BITS-1:0]   a_cost,
	input  logic [VERTEX_BITS-1:0] a_vertex,
	input  logic [COST_BITS-1:0]   b_cost,
	input  logic [VERTEX_BITS-1:0] b_vertex,
	output logic                   a_first
);

	always_comb begin
		a_first = (a_cost < b_cost) || ((a_cost == b_cost) && (a_vertex < b_vertex));
	end

endmodule

// ===== rtl/core/spq_checker.sv =====
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker #(
	parameter int DEPTH       = 16,
	parameter int COST_BITS   = 16,
	parameter int VERTEX_BITS = 8
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_valid,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic [spq_pkg::STATUS_W-1:0] status,
	input logic [COST_BITS-1:0]         front_cost,
	input logic [VERTEX_BITS-1:0]       front_vertex,
	input logic [$clog2(DEPTH+1)-1:0]   entry_count,
	input logic                         is_empty
);

	import spq_pkg::*;

	// a held result transfer keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(front_cost)
			&& $stable(front_vertex) && $stable(entry_count))
		else $error("result changed while stalled");

	// one request at a time: busy right after a transfer in
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken while busy");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_FULL |-> entry_count == DEPTH
			&& front_cost == '0 && front_vertex == '0)
		else $error("full status with room left");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> is_empty && front_cost == '0
			&& front_vertex == '0)
		else $error("empty status with entries stored");

	a_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> is_empty == (entry_count == '0))
		else $error("empty flag disagrees with count");

endmodule

bind sorted_priority_queue spq_checker #(
	.DEPTH       (DEPTH),
	.COST_BITS   (COST_BITS),
	.VERTEX_BITS (VERTEX_BITS)
) u_spq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.status       (status),
	.front_cost   (front_cost),
	.front_vertex (front_vertex),
	.entry_count  (entry_count),
	.is_empty     (is_empty)
);

// ===== tb/sv/sorted_priority_queue_tb.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_queue_tb
// Self-checking bench for the sorted min-priority queue.
//
// A table of directed requests runs first: the empty queue, extreme costs
// and vertices, equal entries, a full queue and the unknown kind. Random
// requests follow, in phases that lean toward inserts or toward pops so the
// queue swings between empty and full. A behavioral copy of the queue
// predicts every result, and each result transfer is compared field by
// field with the oldest prediction. Both sides idle at random, the sink
// holds off once for a long stretch, and the source waits for the queue to
// drain after the table, once among the random requests and at the end.
// ----------------------------------------------------------------------------
module sorted_priority_queue_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import spq_pkg::*;

	localparam int QUEUE_DEPTH = 16;
	localparam int COST_W      = 16;
	localparam int VERTEX_W    = 8;
	localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);

	localparam int CLK_PERIOD       = 12;
	localparam int RESET_CYCLES     = 8;
	localparam int RANDOM_ITEMS     = 1825;
	localparam int PHASE_ITEMS      = 40;
	localparam int LONG_HOLD_AT     = 600;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int DRAIN_AT         = 1200;
	// long enough for the longest insert, which compares every stored entry
	localparam int TAIL_CYCLES      = 3 + QUEUE_DEPTH + 20;
	localparam int LIMIT_CYCLES     = 400000;

	// the package has no name for the fourth code; the queue treats it as a no-op
	localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

	typedef struct packed {
		logic [STATUS_W-1:0] st;
		logic [COST_W-1:0]   cost;
		logic [VERTEX_W-1:0] vertex;
		logic [COUNT_W-1:0]  count;
		logic                empty;
	} queue_reply_t;

	// typed = 1: reply holds the hand-written result; otherwise the model decides
	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [COST_W-1:0]   cost;
		logic [VERTEX_W-1:0] vertex;
		logic                typed;
		queue_reply_t        reply;
	} directed_row_t;

	localparam int DIRECTED_ROWS = 25;
	localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
		// requests on the empty queue
		'{KIND_POP,    16'h0000, 8'h00, 1'b1, '{ST_EMPTY, 16'h0, 8'h0, 5'd0, 1'b1}},
		'{KIND_PEEK,   16'h0000, 8'h00, 1'b1, '{ST_EMPTY, 16'h0, 8'h0, 5'd0, 1'b1}},
		'{KIND_NOP,    16'hFFFF, 8'hFF, 1'b1, '{ST_DONE,  16'h0, 8'h0, 5'd0, 1'b1}},
		// fill up: extremes, equal entries, equal cost with both vertex orders
		'{KIND_INSERT, 16'hFFFF, 8'hFF, 1'b1, '{ST_DONE,  16'h0, 8'h0, 5'd1, 1'b0}},
		'{KIND_INSERT, 16'h0000, 8'h00, 1'b1, '{ST_DONE,  16'h0, 8'h0, 5'd2, 1'b0}},
		'{KIND_PEEK,   16'hFFFF, 8'hFF, 1'b1, '{ST_DONE,  16'h0, 8'h0, 5'd2, 1'b0}},
		'{KIND_INSERT, 16'h0000, 8'hFF, 1'b1, '{ST_DONE,  16'h0, 8'h0, 5'd3, 1'b0}},
		'{KIND_INSERT, 16'hFFFF, 8'h00, 1'b1, '{ST_DONE,  16'h0, 8'h0, 5'd4, 1'b0}},
		'{KIND_INSERT, 16'h8000, 8'h80, 1'b1, '{ST_DONE,  16'h0, 8'h0, 5'd5, 1'b0}},
		'{KIND_INSERT, 16'h8000, 8'h80, 1'b1, '{ST_DONE,  16'h0, 8'h0, 5'd6, 1'b0}},
		'{KIND_INSERT, 16'h8000, 8'h7F, 1'b1, '{ST_DONE,  16'h0, 8'h0, 5'd7, 1'b0}},
		'{KIND_INSERT, 16'h0001, 8'h01, 1'b1, '{ST_DONE,  16'h0, 8'h0, 5'd8, 1'b0}},
		'{KIND_INSERT, 16'h5555, 8'hAA, 1'b1, '{ST_DONE,  16'h0, 8'h0, 5'd9, 1'b0}},
		'{KIND_INSERT, 16'hAAAA, 8'h55, 1'b1, '{ST_DONE,  16'h0, 8'h0, 5'd10, 1'b0}},
		'{KIND_INSERT, 16'h7FFF, 8'hFE, 1'b1, '{ST_DONE,  16'h0, 8'h0, 5'd11, 1'b0}},
		'{KIND_INSERT, 16'h0000, 8'h00, 1'b1, '{ST_DONE,  16'h0, 8'h0, 5'd12, 1'b0}},
		'{KIND_INSERT, 16'h1234, 8'h56, 1'b1, '{ST_DONE,  16'h0, 8'h0, 5'd13, 1'b0}},
		'{KIND_INSERT, 16'hFEDC, 8'hBA, 1'b1, '{ST_DONE,  16'h0, 8'h0, 5'd14, 1'b0}},
		'{KIND_INSERT, 16'h00FF, 8'h01, 1'b1, '{ST_DONE,  16'h0, 8'h0, 5'd15, 1'b0}},
		'{KIND_INSERT, 16'h4000, 8'h40, 1'b1, '{ST_DONE,  16'h0, 8'h0, 5'd16, 1'b0}},
		// full queue: insert refused, no-op keeps the count
		'{KIND_INSERT, 16'h9999, 8'h99, 1'b1, '{ST_FULL,  16'h0, 8'h0, 5'd16, 1'b0}},
		'{KIND_NOP,    16'h0000, 8'h00, 1'b1, '{ST_DONE,  16'h0, 8'h0, 5'd16, 1'b0}},
		// front entries, left to the model
		'{KIND_PEEK,   16'h0000, 8'h00, 1'b0, '0},
		'{KIND_POP,    16'h0000, 8'h00, 1'b0, '0},
		'{KIND_POP,    16'hFFFF, 8'hFF, 1'b0, '0}
	};

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       in_valid;
	logic                       in_stall;
	logic [KIND_W-1:0]          kind;
	logic [COST_W-1:0]          item_cost;
	logic [VERTEX_W-1:0]        item_vertex;
	logic                       out_valid;
	logic                       out_stall;
	logic [STATUS_W-1:0]        status;
	logic [COST_W-1:0]          front_cost;
	logic [VERTEX_W-1:0]        front_vertex;
	logic [COUNT_W-1:0]         entry_count;
	logic                       is_empty;

	// behavioral copy of the queue contents, front at index 0
	logic [COST_W-1:0]          shadow_costs [QUEUE_DEPTH];
	logic [VERTEX_W-1:0]        shadow_vertices [QUEUE_DEPTH];
	int                         shadow_fill = 0;

	queue_reply_t               pending_replies [$];
	int                         mismatches = 0;
	int                         cycle_count = 0;
	bit                         long_hold_req = 1'b0;
	int                         source_calm = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	sorted_priority_queue #(
		.DEPTH       (QUEUE_DEPTH),
		.COST_BITS   (COST_W),
		.VERTEX_BITS (VERTEX_W)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.item_cost    (item_cost),
		.item_vertex  (item_vertex),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.front_cost   (front_cost),
		.front_vertex (front_vertex),
		.entry_count  (entry_count),
		.is_empty     (is_empty)
	);

	// Applies one request to the shadow queue and returns the result it gives.
	// Inserts land ahead of every stored entry that compares equal.
	function automatic queue_reply_t apply_request(logic [KIND_W-1:0] req,
			logic [COST_W-1:0] cost, logic [VERTEX_W-1:0] vertex);
		queue_reply_t r;
		int pos;
		r = '0;
		r.st = ST_DONE;
		case (req) inside
			KIND_INSERT: begin
				if (shadow_fill >= QUEUE_DEPTH) begin
					r.st = ST_FULL;
				end else begin
					pos = 0;
					while (pos < shadow_fill && (shadow_costs[pos] < cost ||
							(shadow_costs[pos] == cost && shadow_vertices[pos] < vertex)))
						pos++;
					for (int i = shadow_fill; i > pos; i--) begin
						shadow_costs[i] = shadow_costs[i-1];
						shadow_vertices[i] = shadow_vertices[i-1];
					end
					shadow_costs[pos] = cost;
					shadow_vertices[pos] = vertex;
					shadow_fill++;
				end
			end
			KIND_POP, KIND_PEEK: begin
				if (shadow_fill == 0) begin
					r.st = ST_EMPTY;
				end else begin
					r.cost = shadow_costs[0];
					r.vertex = shadow_vertices[0];
					if (req == KIND_POP) begin
						for (int i = 0; i + 1 < shadow_fill; i++) begin
							shadow_costs[i] = shadow_costs[i+1];
							shadow_vertices[i] = shadow_vertices[i+1];
						end
						shadow_fill--;
					end
				end
			end
			default: ;
		endcase
		r.count = COUNT_W'(shadow_fill);
		r.empty = (shadow_fill == 0);
		return r;
	endfunction

	// Idle cycles before the next transfer; now and then a stretch of zero idling.
	function automatic int draw_wait(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		return $urandom_range(0, 11);
	endfunction

	task automatic compare_field(string field, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endtask

	// Offers one request from a falling edge and waits for the transfer; the
	// prediction is queued at the accepting edge. valid stays high after the
	// transfer until the next falling edge, where it is either lowered for a
	// gap or carries the next request.
	task automatic push_request(logic [KIND_W-1:0] req, logic [COST_W-1:0] cost,
			logic [VERTEX_W-1:0] vertex, bit typed, queue_reply_t typed_reply);
		queue_reply_t predicted;
		int gap;
		gap = draw_wait(source_calm);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		kind <= req;
		item_cost <= cost;
		item_vertex <= vertex;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = apply_request(req, cost, vertex);
		pending_replies.push_back(typed ? typed_reply : predicted);
	endtask

	// Source pause: nothing offered until every predicted result has come back.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(negedge clk);
	endtask

	// Request source: reset, directed table, then biased random phases.
	initial begin : request_source
		int served;
		int insert_pct;
		int next_phase;
		int pick;
		logic [KIND_W-1:0] req;
		logic [COST_W-1:0] cost;
		logic [VERTEX_W-1:0] vertex;
		bit hold_done;
		bit drain_done;

		in_valid = 1'b0;
		kind = KIND_INSERT;
		item_cost = '0;
		item_vertex = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIRECTED_ROWS; i++)
			push_request(DIRECTED[i].kind, DIRECTED[i].cost, DIRECTED[i].vertex,
				DIRECTED[i].typed, DIRECTED[i].reply);
		wait_drained();

		served = 0;
		next_phase = 0;
		insert_pct = 50;
		hold_done = 1'b0;
		drain_done = 1'b0;
		while (served < RANDOM_ITEMS) begin
			// each phase leans one way so the queue runs into both the full
			// and the empty boundary
			if (served >= next_phase) begin
				insert_pct = $urandom_range(15, 85);
				next_phase = served + PHASE_ITEMS;
			end
			if (served >= LONG_HOLD_AT && !hold_done) begin
				long_hold_req = 1'b1;
				hold_done = 1'b1;
			end
			if (served >= DRAIN_AT && !drain_done) begin
				wait_drained();
				drain_done = 1'b1;
			end

			pick = $urandom_range(0, 99);
			if (pick < 3)
				req = KIND_NOP;
			else if (pick < 3 + insert_pct)
				req = KIND_INSERT;
			else if ($urandom_range(0, 3) == 0)
				req = KIND_PEEK;
			else
				req = KIND_POP;

			// narrow values give plenty of equal costs and equal entries
			pick = $urandom_range(0, 9);
			if (pick < 4) begin
				cost = COST_W'($urandom_range(0, 7));
				vertex = VERTEX_W'($urandom_range(0, 3));
			end else if (pick == 4) begin
				cost = $urandom_range(0, 1) ? '1 : '0;
				vertex = $urandom_range(0, 1) ? '1 : '0;
			end else begin
				cost = COST_W'($urandom);
				vertex = VERTEX_W'($urandom);
			end

			push_request(req, cost, vertex, 1'b0, '0);
			if (req != KIND_NOP)
				served++;
		end

		wait_drained();
		// a stray extra transfer would still show up here
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Result sink: random stall before each transfer, one long hold-off on
	// request so the output register fills and the queue stalls its input.
	initial begin : result_sink
		queue_reply_t want;
		int gap;
		int calm;
		calm = 0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				repeat (LONG_HOLD_CYCLES) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
			end
			gap = draw_wait(calm);
			repeat (gap) begin
				@(negedge clk);
				out_stall <= 1'b1;
			end
			@(negedge clk);
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
			if (pending_replies.size() == 0) begin
				$error("result transfer with no request outstanding");
				mismatches++;
			end else begin
				want = pending_replies.pop_front();
				compare_field("status", want.st, status);
				compare_field("front_cost", want.cost, front_cost);
				compare_field("front_vertex", want.vertex, front_vertex);
				compare_field("entry_count", want.count, entry_count);
				compare_field("is_empty", want.empty, is_empty);
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule

// ===== filelist.f =====
rtl/core/spq_pkg.sv
rtl/core/spq_cmp.sv
rtl/core/sorted_priority_queue.sv
rtl/core/spq_checker.sv
tb/sv/sorted_priority_queue_tb.sv
